### hdl/assert_macros.svh
// Assertion helpers. Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge of clk_i.
`define CR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define CR_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

### hdl/catrom_pkg.sv
package catrom_pkg;

  localparam int COORD_W = 32;
  localparam int CNT_W   = 7;
  localparam int ACC_W   = 40;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [5:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0]        curve_param;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] deriv_x;
    logic signed [31:0] deriv_y;
    logic signed [31:0] deriv_z;
    logic               empty_error;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_N,
    MUL_H,
    MUL_G
  } mul_src_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_H,
    ACC_G
  } acc_dst_e;

  typedef enum logic [1:0] {
    ADD_ZERO,
    ADD_B1,
    ADD_B1X2,
    ADD_B2
  } addend_e;

  typedef struct packed {
    logic     coef;
    mul_src_e mul_src;
    acc_dst_e acc_dst;
    addend_e  addend;
  } alu_ctrl_t;

endpackage

### hdl/catrom_point_mem.sv
module catrom_point_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  catrom_pkg::point_t wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output catrom_pkg::point_t rdata_o
);
  import catrom_pkg::*;

  point_t mem_q [DEPTH];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/catrom_axis_alu.sv
module catrom_axis_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  catrom_pkg::alu_ctrl_t                ctrl_i,
  input  logic [catrom_pkg::CNT_W-1:0]         n_i,
  input  logic [FRAC_BITS-1:0]                 u_i,
  input  logic signed [catrom_pkg::COORD_W-1:0] p0_i,
  input  logic signed [catrom_pkg::COORD_W-1:0] p1_i,
  input  logic signed [catrom_pkg::COORD_W-1:0] p2_i,
  input  logic signed [catrom_pkg::COORD_W-1:0] p3_i,
  output logic [catrom_pkg::CNT_W-1:0]         seg_o,
  output logic [FRAC_BITS-1:0]                 frac_o,
  output logic signed [catrom_pkg::COORD_W-1:0] pos_o,
  output logic signed [catrom_pkg::COORD_W-1:0] deriv_o
);
  import catrom_pkg::*;

  localparam int PW = ACC_W + FRAC_BITS + 1;

  function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
    lo = ACC_W'($signed({1'b1, {(COORD_W-1){1'b0}}}));
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  logic signed [ACC_W-1:0] h_q, g_q, b1_q, b2_q;
  logic signed [PW-1:0]    prod_q;

  logic signed [ACC_W-1:0] e0, e1, e2, e3, d12;
  logic signed [ACC_W-1:0] b0_c, b1_c, b2_c;
  logic signed [ACC_W-1:0] mul_a;
  logic signed [FRAC_BITS:0] mul_b;
  logic signed [PW-1:0]    prod_d;
  logic signed [ACC_W-1:0] prod_fl, addend, acc_sum, pos_wide;

  assign e0 = ACC_W'(p0_i);
  assign e1 = ACC_W'(p1_i);
  assign e2 = ACC_W'(p2_i);
  assign e3 = ACC_W'(p3_i);

  // doubled Catmull-Rom coefficients, shift and add only
  assign d12  = e1 - e2;
  assign b0_c = (e3 - e0) + (d12 <<< 1) + d12;
  assign b1_c = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
  assign b2_c = e2 - e0;

  always_comb begin
    unique case (ctrl_i.mul_src)
      MUL_N:    mul_a = $signed({{(ACC_W-CNT_W){1'b0}}, n_i});
      MUL_H:    mul_a = h_q;
      MUL_G:    mul_a = g_q;
      MUL_NONE: mul_a = '0;
    endcase
  end

  assign mul_b  = $signed({1'b0, u_i});
  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // arithmetic shift of the signed product rounds toward minus infinity
  assign prod_fl = ACC_W'(prod_q >>> FRAC_BITS);

  always_comb begin
    unique case (ctrl_i.addend)
      ADD_B1:   addend = b1_q;
      ADD_B1X2: addend = b1_q <<< 1;
      ADD_B2:   addend = b2_q;
      ADD_ZERO: addend = '0;
    endcase
  end

  assign acc_sum = prod_fl + addend;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_src != MUL_NONE) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.coef) begin
      b1_q <= b1_c;
      b2_q <= b2_c;
      h_q  <= b0_c;
      g_q  <= (b0_c <<< 1) + b0_c;
    end else begin
      if (ctrl_i.acc_dst == ACC_H) begin
        h_q <= acc_sum;
      end
      if (ctrl_i.acc_dst == ACC_G) begin
        g_q <= acc_sum;
      end
    end
  end

  // last position step folds the final product shift and the halving together
  assign pos_wide = e1 + ACC_W'(prod_q >>> (FRAC_BITS + 1));
  assign pos_o    = sat_coord(pos_wide);
  assign deriv_o  = sat_coord(g_q >>> 1);

  assign seg_o  = prod_q[FRAC_BITS +: CNT_W];
  assign frac_o = prod_q[FRAC_BITS-1:0];

endmodule

### hdl/catmull_rom_point_eval.sv
// Closed-loop Catmull-Rom evaluator over a table of Q16.16 control points.
// Input channel (in_valid_i/in_ready_o, in_data_i): a load item (opcode 0)
// writes one point in the accept cycle and gives no result; the block is
// ready again in the next cycle. An index at or beyond MAX_POINTS is dropped.
// An evaluate item (opcode 1) gives one result on the output channel
// (out_valid_o/out_ready_i, out_data_o): position and d/dt for x, y and z.
// An evaluate runs from accept to out_valid_o through one scale step, one
// split step, table reads of the four points (one read port), seven steps
// per axis on the one shared multiplier and one step into the output register.
// in_ready_o returns with out_valid_o, so a new evaluate is taken only once
// the previous result has gone to the output register. With a zero point count
// the evaluate goes straight to the output step with empty_error set.
// The block holds one item at a time and drops in_ready_o while it works.
// A finished result waits in the output register; if the receiver stalls,
// the next evaluate is taken but its result holds until the slot frees.
// cfg_we_i/cfg_wdata_i write the point count; write it only while idle.
// Reset clears the point count and the handshake state; the point table
// is undefined until loaded.
`include "assert_macros.svh"

module catmull_rom_point_eval #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [catrom_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  catrom_pkg::in_item_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output catrom_pkg::out_item_t         out_data_o
);
  import catrom_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCALE  = 3'd1;
  localparam logic [2:0] S_SPLIT  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_AXIS   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  localparam logic [2:0] STEP_COEF = 3'd0;
  localparam logic [2:0] STEP_M1   = 3'd1;
  localparam logic [2:0] STEP_M2   = 3'd2;
  localparam logic [2:0] STEP_M3   = 3'd3;
  localparam logic [2:0] STEP_M4   = 3'd4;
  localparam logic [2:0] STEP_M5   = 3'd5;
  localparam logic [2:0] STEP_OUT  = 3'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [2:0] RD_LAST = 3'd4;

  function automatic logic signed [COORD_W-1:0] axis_coord(point_t p, logic [1:0] axis);
    unique case (axis)
      AXIS_Y:  return p.y;
      AXIS_Z:  return p.z;
      default: return p.x;
    endcase
  endfunction

  logic [2:0]        state_q;
  logic [CNT_W-1:0]  count_q, n_sat;
  logic [2:0]        rd_cnt_q, step_q;
  logic [1:0]        axis_q;
  logic              out_valid_q;

  logic [FRAC_BITS-1:0] u_q;
  logic [CNT_W-1:0]     addr_q, addr_next;
  point_t               pts_q [4];
  out_item_t            res_q, out_q;

  logic       in_fire, load_fire, eval_fire, out_free, rd_en;
  point_t     wr_point, rd_point;
  alu_ctrl_t  alu_ctrl;
  logic [CNT_W-1:0]          alu_seg;
  logic [FRAC_BITS-1:0]      alu_frac;
  logic signed [COORD_W-1:0] alu_pos, alu_deriv;

  assign n_sat = (32'(count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : count_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && (in_data_i.opcode == OP_LOAD) &&
                      (32'(in_data_i.point_index) < MAX_POINTS);
  assign eval_fire  = in_fire && (in_data_i.opcode == OP_EVAL);
  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_en      = (state_q == S_READ) && (rd_cnt_q != RD_LAST);
  assign addr_next  = (addr_q + CNT_W'(1) == n_sat) ? '0 : addr_q + CNT_W'(1);

  assign wr_point = '{x: in_data_i.coord_x, y: in_data_i.coord_y, z: in_data_i.coord_z};

  catrom_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (IDX_W'(in_data_i.point_index)),
    .wdata_i (wr_point),
    .re_i    (rd_en),
    .raddr_i (IDX_W'(addr_q)),
    .rdata_o (rd_point)
  );

  // step schedule: position and derivative chains alternate on the multiplier
  always_comb begin
    alu_ctrl = '{coef: 1'b0, mul_src: MUL_NONE, acc_dst: ACC_NONE, addend: ADD_ZERO};
    if (state_q == S_SCALE) begin
      alu_ctrl.mul_src = MUL_N;
    end else if (state_q == S_AXIS) begin
      unique case (step_q)
        STEP_COEF: alu_ctrl.coef = 1'b1;
        STEP_M1: begin
          alu_ctrl.mul_src = MUL_H;
        end
        STEP_M2: begin
          alu_ctrl.acc_dst = ACC_H;
          alu_ctrl.addend  = ADD_B1;
          alu_ctrl.mul_src = MUL_G;
        end
        STEP_M3: begin
          alu_ctrl.acc_dst = ACC_G;
          alu_ctrl.addend  = ADD_B1X2;
          alu_ctrl.mul_src = MUL_H;
        end
        STEP_M4: begin
          alu_ctrl.acc_dst = ACC_H;
          alu_ctrl.addend  = ADD_B2;
          alu_ctrl.mul_src = MUL_G;
        end
        STEP_M5: begin
          alu_ctrl.acc_dst = ACC_G;
          alu_ctrl.addend  = ADD_B2;
          alu_ctrl.mul_src = MUL_H;
        end
        default: ;
      endcase
    end
  end

  catrom_axis_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i   (clk_i),
    .ctrl_i  (alu_ctrl),
    .n_i     (n_sat),
    .u_i     (u_q),
    .p0_i    (axis_coord(pts_q[0], axis_q)),
    .p1_i    (axis_coord(pts_q[1], axis_q)),
    .p2_i    (axis_coord(pts_q[2], axis_q)),
    .p3_i    (axis_coord(pts_q[3], axis_q)),
    .seg_o   (alu_seg),
    .frac_o  (alu_frac),
    .pos_o   (alu_pos),
    .deriv_o (alu_deriv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      step_q      <= STEP_COEF;
      axis_q      <= AXIS_X;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (eval_fire) begin
            state_q <= (n_sat == '0) ? S_RESULT : S_SCALE;
          end
        end
        S_SCALE: state_q <= S_SPLIT;
        S_SPLIT: begin
          rd_cnt_q <= '0;
          state_q  <= S_READ;
        end
        S_READ: begin
          rd_cnt_q <= rd_cnt_q + 3'd1;
          if (rd_cnt_q == RD_LAST) begin
            step_q  <= STEP_COEF;
            axis_q  <= AXIS_X;
            state_q <= S_AXIS;
          end
        end
        S_AXIS: begin
          if (step_q == STEP_OUT) begin
            step_q <= STEP_COEF;
            axis_q <= axis_q + 2'd1;
            if (axis_q == AXIS_Z) begin
              state_q <= S_RESULT;
            end
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      u_q <= in_data_i.curve_param[FRAC_BITS-1:0];
      if (n_sat == '0) begin
        res_q <= '{empty_error: 1'b1, default: '0};
      end else begin
        res_q.empty_error <= 1'b0;
      end
    end
    if (state_q == S_SPLIT) begin
      // start one point behind the segment, wrapping at the count
      addr_q <= (alu_seg == '0) ? n_sat - CNT_W'(1) : alu_seg - CNT_W'(1);
      u_q    <= alu_frac;
    end
    if (rd_en) begin
      addr_q <= addr_next;
    end
    if (state_q == S_READ && rd_cnt_q != '0) begin
      pts_q[rd_cnt_q[1:0] - 2'd1] <= rd_point;
    end
    if (state_q == S_AXIS && step_q == STEP_OUT) begin
      unique case (axis_q)
        AXIS_X: begin
          res_q.pos_x   <= alu_pos;
          res_q.deriv_x <= alu_deriv;
        end
        AXIS_Y: begin
          res_q.pos_y   <= alu_pos;
          res_q.deriv_y <= alu_deriv;
        end
        AXIS_Z: begin
          res_q.pos_z   <= alu_pos;
          res_q.deriv_z <= alu_deriv;
        end
        default: ;
      endcase
    end
    if (state_q == S_RESULT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CR_ASSERT(a_rd_addr_range, (state_q == S_READ) |-> (addr_q < n_sat), "read past count")
  `CR_ASSERT(a_axis_range, (state_q == S_AXIS) |-> (axis_q <= AXIS_Z), "axis out of range")
  `CR_ASSERT(a_empty_zero, (out_valid_o && out_data_o.empty_error) |-> (out_data_o.pos_x == 0), "error with data")
  `CR_ASSERT_NEXT(a_busy_after_eval, eval_fire, !in_ready_o, "ready after evaluate accept")
  `CR_ASSERT_NEXT(a_result_held, state_q == S_RESULT && !out_free, state_q == S_RESULT, "result dropped")

endmodule

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import catrom_pkg::*;

  localparam int TableDepth = 64;
  localparam int FracBits = 16;
  localparam int SettleCycles = 40;
  localparam int PhaseItems = 95;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;

  typedef enum logic [2:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_MASK,
    RX_HOLD
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;

  // Predictor state
  point_t ctrl_pts[TableDepth];
  logic [CNT_W-1:0] loop_count = '0;
  out_item_t curve_expected[$];
  int mismatch_count = 0;

  // Stimulus side
  in_item_t queued_cmds[$];
  logic [TableDepth-1:0] pts_loaded = '0;
  logic in_accepted = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  rx_mode_e rx_mode = RX_ALWAYS;
  int rx_span = 0;
  logic [7:0] rx_mask = 8'hFF;

  catmull_rom_point_eval #(
    .MAX_POINTS(TableDepth),
    .FRAC_BITS (FracBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] sat_s32(longint v);
    if (v > S32Max) return 32'sh7FFF_FFFF;
    if (v < S32Min) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Doubled basis coefficients keep every term an exact integer.
  function automatic void catmull_axis(input longint p0, input longint p1,
                                       input longint p2, input longint p3,
                                       input longint u,
                                       output logic signed [31:0] pos,
                                       output logic signed [31:0] slope);
    longint b0, b1, b2, h, g;
    b0 = -p0 + 3 * p1 - 3 * p2 + p3;
    b1 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    b2 = p2 - p0;
    h = ((b0 * u) >>> FracBits) + b1;
    h = ((h * u) >>> FracBits) + b2;
    h = (h * u) >>> FracBits;
    pos = sat_s32(p1 + (h >>> 1));
    g = ((3 * b0 * u) >>> FracBits) + 2 * b1;
    g = ((g * u) >>> FracBits) + b2;
    slope = sat_s32(g >>> 1);
  endfunction

  function automatic out_item_t predict_curve_point(logic [31:0] param);
    out_item_t r;
    longint unsigned scaled;
    longint u;
    int n, seg, i0, i1, i2, i3;
    r = '0;
    n = (int'(loop_count) > TableDepth) ? TableDepth : int'(loop_count);
    if (n == 0) begin
      r.empty_error = 1'b1;
      return r;
    end
    scaled = 64'(param) * 64'(n);
    seg = int'((scaled >> FracBits) % 64'(n));
    u = longint'(scaled & ((64'd1 << FracBits) - 1));
    i0 = (seg + n - 1) % n;
    i1 = seg;
    i2 = (seg + 1) % n;
    i3 = (seg + 2) % n;
    catmull_axis(ctrl_pts[i0].x, ctrl_pts[i1].x, ctrl_pts[i2].x, ctrl_pts[i3].x, u,
                 r.pos_x, r.deriv_x);
    catmull_axis(ctrl_pts[i0].y, ctrl_pts[i1].y, ctrl_pts[i2].y, ctrl_pts[i3].y, u,
                 r.pos_y, r.deriv_y);
    catmull_axis(ctrl_pts[i0].z, ctrl_pts[i1].z, ctrl_pts[i2].z, ctrl_pts[i3].z, u,
                 r.pos_z, r.deriv_z);
    return r;
  endfunction

  function automatic void check_curve_point(out_item_t want, out_item_t got);
    if (got.pos_x !== want.pos_x) begin
      $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
      mismatch_count++;
    end
    if (got.pos_y !== want.pos_y) begin
      $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
      mismatch_count++;
    end
    if (got.pos_z !== want.pos_z) begin
      $error("pos_z: expected %0d, got %0d", want.pos_z, got.pos_z);
      mismatch_count++;
    end
    if (got.deriv_x !== want.deriv_x) begin
      $error("deriv_x: expected %0d, got %0d", want.deriv_x, got.deriv_x);
      mismatch_count++;
    end
    if (got.deriv_y !== want.deriv_y) begin
      $error("deriv_y: expected %0d, got %0d", want.deriv_y, got.deriv_y);
      mismatch_count++;
    end
    if (got.deriv_z !== want.deriv_z) begin
      $error("deriv_z: expected %0d, got %0d", want.deriv_z, got.deriv_z);
      mismatch_count++;
    end
    if (got.empty_error !== want.empty_error) begin
      $error("empty_error: expected %0b, got %0b", want.empty_error, got.empty_error);
      mismatch_count++;
    end
  endfunction

  // Monitor: track the config, mirror the table, check results
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_accepted = 1'b0;
    end else begin
      in_accepted = in_valid_i && in_ready_o;
      if (cfg_we_i) loop_count = cfg_wdata_i;
      if (in_accepted) begin
        if (in_data_i.opcode == OP_LOAD) begin
          ctrl_pts[in_data_i.point_index] = '{x: in_data_i.coord_x, y: in_data_i.coord_y,
                                              z: in_data_i.coord_z};
        end else begin
          curve_expected = {curve_expected, predict_curve_point(in_data_i.curve_param)};
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (curve_expected.size() == 0) begin
          $error("result with no evaluate item pending");
          mismatch_count++;
        end else begin
          check_curve_point(curve_expected.pop_front(), out_data_o);
        end
      end
    end
  end

  // Sender: bursts of items separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (queued_cmds.size() > 0) begin
        in_data_i <= queued_cmds.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: switch between stall styles every so often
  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 4));
      rx_span = $urandom_range(10, 150);
      rx_mask = 8'($urandom);
    end
    rx_span--;
    rx_mask = {rx_mask[6:0], rx_mask[7]};
    case (rx_mode)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 7) == 0);
      RX_MASK:   out_ready_i <= rx_mask[0];
      default:   out_ready_i <= 1'b0;
    endcase
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_curve_param();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {16'h0, 16'($urandom_range(0, 65535))};
      3: return 32'($urandom_range(0, 255)) << 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_load(int idx, logic signed [31:0] x,
                                     logic signed [31:0] y, logic signed [31:0] z);
    in_item_t it;
    it.opcode = OP_LOAD;
    it.point_index = 6'(idx);
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.curve_param = $urandom;
    queued_cmds = {queued_cmds, it};
    pts_loaded[idx] = 1'b1;
  endfunction

  function automatic void queue_eval(logic [31:0] param);
    in_item_t it;
    it.opcode = OP_EVAL;
    it.point_index = 6'($urandom);
    it.coord_x = $urandom;
    it.coord_y = $urandom;
    it.coord_z = $urandom;
    it.curve_param = param;
    queued_cmds = {queued_cmds, it};
  endfunction

  // Drain everything, then give a trailing load time to land.
  task automatic wait_idle();
    while (queued_cmds.size() != 0 || in_valid_i || curve_expected.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_point_count(logic [CNT_W-1:0] n);
    wait_idle();
    @(negedge clk_i);
    cfg_wdata_i <= n;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int phase_counts[10];
    int eff;
    phase_counts = '{64, 2, 127, 3, 0, 65, 9, 1, 33, 64};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty loop right after reset
    queue_eval(32'h0);
    queue_eval(32'hFFFF_FFFF);
    queue_load(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
    queue_load(1, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1);
    queue_load(2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    queue_load(3, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    queue_load(63, rand_coord(), rand_coord(), rand_coord());

    write_point_count(7'd4);
    queue_eval(32'h0);
    queue_eval(32'hFFFF_FFFF);
    queue_eval(32'h0000_4000);
    queue_eval(32'h0000_C000);
    queue_eval(32'h0001_0000);
    queue_eval(32'h0000_3FFF);

    // Single point: all four neighbors coincide
    write_point_count(7'd1);
    queue_eval(32'h0000_8000);
    queue_eval(32'hFFFF_FFFF);

    foreach (phase_counts[p]) begin
      write_point_count(CNT_W'(phase_counts[p]));
      eff = (phase_counts[p] > TableDepth) ? TableDepth : phase_counts[p];
      for (int i = 0; i < eff; i++)
        if (!pts_loaded[i]) queue_load(i, rand_coord(), rand_coord(), rand_coord());
      repeat (PhaseItems) begin
        if ($urandom_range(0, 9) < 6) queue_eval(rand_curve_param());
        else queue_load($urandom_range(0, TableDepth - 1), rand_coord(), rand_coord(),
                        rand_coord());
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

### catmull_rom_point_eval.f
+incdir+hdl
hdl/catrom_pkg.sv
hdl/catrom_point_mem.sv
hdl/catrom_axis_alu.sv
hdl/catmull_rom_point_eval.sv
verif/tb.sv
